// File: src/nearest_value_request_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// nearest value request scheduler assertion macros
// shared assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef NEAREST_VALUE_REQUEST_SCHEDULER_TOP_MACROS_SVH
`define NEAREST_VALUE_REQUEST_SCHEDULER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NVRS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NVRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/nvrs_pkg.sv
// ----------------------------------------------------------------------------
// nvrs_pkg
// widths, codes and state type of the nearest value request scheduler
// ----------------------------------------------------------------------------
package nvrs_pkg;

	localparam int VALUE_W   = 10;
	localparam int SOURCE_W  = 4;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;
	localparam int LAST_W    = 11;

	localparam logic [LAST_W-1:0] FAR_DISTANCE = LAST_W'(1000);
	localparam logic [LAST_W-1:0] LAST_RESET   = '1;

	localparam int RESET_CAPACITY = 4;
	localparam int RESET_SOURCES  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_BOARD_CAPACITY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SOURCES    = CFG_IDX_W'(1);

	localparam logic MODE_POST = 1'b0;
	localparam logic MODE_DONE = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_SHIFT  = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

endpackage

// File: src/nearest_value_request_scheduler_top.sv
// ----------------------------------------------------------------------------
// nearest value request scheduler
// request board with nearest-to-last-served selection, oldest wins ties
// ----------------------------------------------------------------------------
//
//  channel   handshake             payload
//  -------   -------------------   -----------------------------------------
//  cfg       cfg_we                cfg_index, cfg_wdata
//  in        in_valid / in_stall   mode, order_value, source_id
//  out       out_valid / out_stall served_value, served_source, dropped
//
//  a serve passes decide, then a scan of each board entry through the single
//  distance comparator, then remove/compact and emit; a dropped post passes
//  emit only, and an item that serves nothing passes decide only
//  reset clears the board, last served to -1, capacity and live count to 4
//  in_stall is high from the cycle after an item is accepted until the block
//  is idle again; a pending result waits in the output register under out_stall
//
module nearest_value_request_scheduler_top #(
	parameter int BOARD_DEPTH = 16,
	parameter int MAX_SOURCES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nvrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nvrs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           mode,
	input  logic [nvrs_pkg::VALUE_W-1:0]   order_value,
	input  logic [nvrs_pkg::SOURCE_W-1:0]  source_id,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [nvrs_pkg::VALUE_W-1:0]   served_value,
	output logic [nvrs_pkg::SOURCE_W-1:0]  served_source,
	output logic                           dropped
);

	localparam int IDX_W  = (BOARD_DEPTH > 1) ? $clog2(BOARD_DEPTH) : 1;
	localparam int CNT_W  = $clog2(BOARD_DEPTH + 1);
	localparam int LIVE_W = $clog2(MAX_SOURCES + 1);
	localparam int CMP_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
	localparam int CFG_CMP_W = (CMP_W > nvrs_pkg::CFG_W) ? CMP_W : nvrs_pkg::CFG_W;
	localparam int VW     = nvrs_pkg::VALUE_W;
	localparam int SW     = nvrs_pkg::SOURCE_W;
	localparam int LW     = nvrs_pkg::LAST_W;

	localparam int CAP_RST_I  = (BOARD_DEPTH < nvrs_pkg::RESET_CAPACITY) ?
		BOARD_DEPTH : nvrs_pkg::RESET_CAPACITY;
	localparam int LIVE_RST_I = (MAX_SOURCES < nvrs_pkg::RESET_SOURCES) ?
		MAX_SOURCES : nvrs_pkg::RESET_SOURCES;
	localparam logic [CNT_W-1:0]  CAP_RST  = CNT_W'(CAP_RST_I);
	localparam logic [LIVE_W-1:0] LIVE_RST = LIVE_W'(LIVE_RST_I);
	localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(BOARD_DEPTH);

	nvrs_pkg::state_t state_q;

	// board storage, oldest entry at index 0
	logic [VW-1:0] entry_value_q  [BOARD_DEPTH];
	logic [SW-1:0] entry_source_q [BOARD_DEPTH];

	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cap_q;
	logic [LIVE_W-1:0] live_q;
	logic [LW-1:0]     last_q;

	// scan unit state
	logic [IDX_W-1:0] scan_idx_q;
	logic [IDX_W-1:0] pick_q;
	logic [LW-1:0]    best_q;
	logic [VW-1:0]    pick_value_q;
	logic [SW-1:0]    pick_source_q;

	// result waiting for the output register
	logic [VW-1:0] res_value_q;
	logic [SW-1:0] res_source_q;
	logic          res_drop_q;

	logic          out_valid_q;
	logic [VW-1:0] served_value_q;
	logic [SW-1:0] served_source_q;
	logic          dropped_q;

	logic                 in_accept;
	logic                 board_full;
	logic [LIVE_W-1:0]    live_dec;
	logic                 cap_lower;
	logic                 serve_now;
	logic                 scan_last;
	logic                 out_free;
	logic [VW-1:0]        scan_value;
	logic signed [LW:0]   diff;
	logic [LW:0]          diff_abs;
	logic [LW-1:0]        scan_dist;
	logic                 nearer;
	logic [CFG_CMP_W-1:0] cfg_ext;
	logic [CNT_W-1:0]     cfg_cap;
	logic [LIVE_W-1:0]    cfg_live;
	logic [CNT_W-1:0]     count_last;

	assign in_stall  = (state_q != nvrs_pkg::ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// a post is dropped when the board is at its current capacity
	assign board_full = (count_q >= cap_q) || (count_q >= DEPTH_C);

	// source done: capacity follows the live count down
	assign live_dec  = live_q - LIVE_W'(1);
	assign cap_lower = (CMP_W'(live_dec) < CMP_W'(cap_q));

	assign serve_now = (count_q >= cap_q) && (live_q != '0) && (count_q != '0);

	assign count_last = count_q - CNT_W'(1);
	assign scan_last  = (CNT_W'(scan_idx_q) == count_last);

	// shared distance comparator
	assign scan_value = entry_value_q[scan_idx_q];
	assign diff       = $signed({2'b00, scan_value}) - $signed({last_q[LW-1], last_q});
	assign diff_abs   = diff[LW] ? (LW+1)'(-diff) : diff;
	assign scan_dist  = diff_abs[LW-1:0];
	assign nearer     = (scan_dist < best_q);

	// register write clamping
	assign cfg_ext  = CFG_CMP_W'(cfg_wdata);
	assign cfg_cap  = (cfg_ext > CFG_CMP_W'(BOARD_DEPTH)) ? DEPTH_C : CNT_W'(cfg_ext);
	assign cfg_live = (cfg_ext > CFG_CMP_W'(MAX_SOURCES)) ?
		LIVE_W'(MAX_SOURCES) : LIVE_W'(cfg_ext);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= nvrs_pkg::ST_IDLE;
			count_q    <= '0;
			cap_q      <= CAP_RST;
			live_q     <= LIVE_RST;
			last_q     <= nvrs_pkg::LAST_RESET;
			scan_idx_q <= '0;
			pick_q     <= '0;
			best_q     <= nvrs_pkg::FAR_DISTANCE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nvrs_pkg::REG_BOARD_CAPACITY: cap_q <= cfg_cap;
					nvrs_pkg::REG_NUM_SOURCES:    live_q <= cfg_live;
					default: ;
				endcase
			end
			case (state_q)
				nvrs_pkg::ST_IDLE: begin
					if (in_accept) begin
						if (mode == nvrs_pkg::MODE_POST) begin
							if (board_full) begin
								state_q <= nvrs_pkg::ST_EMIT;
							end else begin
								count_q <= count_q + CNT_W'(1);
								state_q <= nvrs_pkg::ST_DECIDE;
							end
						end else begin
							// source done with no live source leaves state alone
							if (live_q != '0) begin
								live_q <= live_dec;
								if (cap_lower)
									cap_q <= cap_q - CNT_W'(1);
							end
							state_q <= nvrs_pkg::ST_DECIDE;
						end
					end
				end
				nvrs_pkg::ST_DECIDE: begin
					scan_idx_q <= '0;
					pick_q     <= '0;
					best_q     <= nvrs_pkg::FAR_DISTANCE;
					state_q    <= serve_now ? nvrs_pkg::ST_SCAN : nvrs_pkg::ST_IDLE;
				end
				nvrs_pkg::ST_SCAN: begin
					// strict compare keeps the oldest entry on a tie
					if (nearer) begin
						best_q <= scan_dist;
						pick_q <= scan_idx_q;
					end
					if (scan_last)
						state_q <= nvrs_pkg::ST_SHIFT;
					else
						scan_idx_q <= scan_idx_q + IDX_W'(1);
				end
				nvrs_pkg::ST_SHIFT: begin
					last_q  <= {1'b0, pick_value_q};
					count_q <= count_last;
					state_q <= nvrs_pkg::ST_EMIT;
				end
				nvrs_pkg::ST_EMIT: begin
					if (out_free)
						state_q <= nvrs_pkg::ST_IDLE;
				end
				default: state_q <= nvrs_pkg::ST_IDLE;
			endcase
		end
	end

	// board storage: append at the tail, close up behind the served entry
	always_ff @(posedge clk) begin
		if (state_q == nvrs_pkg::ST_IDLE && in_accept && mode == nvrs_pkg::MODE_POST
				&& !board_full) begin
			entry_value_q[count_q[IDX_W-1:0]]  <= order_value;
			entry_source_q[count_q[IDX_W-1:0]] <= source_id;
		end
		if (state_q == nvrs_pkg::ST_SHIFT) begin
			for (int i = 0; i < BOARD_DEPTH - 1; i++) begin
				if (IDX_W'(i) >= pick_q) begin
					entry_value_q[i]  <= entry_value_q[i+1];
					entry_source_q[i] <= entry_source_q[i+1];
				end
			end
		end
	end

	// pick payload and pending result
	always_ff @(posedge clk) begin
		if (state_q == nvrs_pkg::ST_SCAN && (nearer || scan_idx_q == '0)) begin
			pick_value_q  <= nearer ? scan_value : entry_value_q[0];
			pick_source_q <= nearer ? entry_source_q[scan_idx_q] : entry_source_q[0];
		end
		if (state_q == nvrs_pkg::ST_IDLE && in_accept && mode == nvrs_pkg::MODE_POST
				&& board_full) begin
			res_value_q  <= '0;
			res_source_q <= '0;
			res_drop_q   <= 1'b1;
		end else if (state_q == nvrs_pkg::ST_SHIFT) begin
			res_value_q  <= pick_value_q;
			res_source_q <= pick_source_q;
			res_drop_q   <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == nvrs_pkg::ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && state_q == nvrs_pkg::ST_EMIT) begin
			served_value_q  <= res_value_q;
			served_source_q <= res_source_q;
			dropped_q       <= res_drop_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign served_value  = served_value_q;
	assign served_source = served_source_q;
	assign dropped       = dropped_q;

endmodule

// File: src/nvrs_checker.sv
// ----------------------------------------------------------------------------
// nvrs_checker
// port-level checks on the nearest value request scheduler
// ----------------------------------------------------------------------------
`include "nearest_value_request_scheduler_top_macros.svh"

module nvrs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [nvrs_pkg::VALUE_W-1:0]   served_value,
	input logic [nvrs_pkg::SOURCE_W-1:0]  served_source,
	input logic                           dropped
);

	// held result keeps its payload
	`NVRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(served_value) && $stable(served_source) && $stable(dropped),
		"stalled result changed")

	// a dropped post carries no request
	`NVRS_ASSERT_NOW(a_drop_empty, out_valid && dropped,
		served_value == '0 && served_source == '0, "dropped item with payload")

	// one item at a time: busy right after an accept
	`NVRS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
		"second item taken back to back")

	// no result ahead of its item: a dropped post passes emit and the output register
	`NVRS_ASSERT_NEXT(a_result_not_early, in_valid && !in_stall && !out_valid, !out_valid,
		"result ahead of its item")

endmodule

bind nearest_value_request_scheduler_top nvrs_checker u_nvrs_checker (.*);

// File: tb/nvrs_grant_checker.sv
// ----------------------------------------------------------------------------
// nvrs_grant_checker
// watches the request and grant channels of the nearest value request
// scheduler, predicts every grant from its own copy of the board and
// compares each accepted grant with the oldest one still owed
// ----------------------------------------------------------------------------
module nvrs_grant_checker #(
	parameter int BOARD_DEPTH = 16,
	parameter int MAX_SOURCES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nvrs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nvrs_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           mode,
	input  logic [nvrs_pkg::VALUE_W-1:0]   order_value,
	input  logic [nvrs_pkg::SOURCE_W-1:0]  source_id,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [nvrs_pkg::VALUE_W-1:0]   served_value,
	input  logic [nvrs_pkg::SOURCE_W-1:0]  served_source,
	input  logic                           dropped,
	output int                             fail_count,
	output int                             grants_owed
);
	import nvrs_pkg::*;

	localparam int FAR = int'(FAR_DISTANCE);

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [SOURCE_W-1:0] source;
		logic                dropped;
	} grant_t;

	logic [VALUE_W-1:0]  board_value  [BOARD_DEPTH];
	logic [SOURCE_W-1:0] board_source [BOARD_DEPTH];
	int                  board_fill;
	int                  last_value;
	int                  live_sources;
	int                  cap_now;
	grant_t              owed_grants [$];

	initial fail_count = 0;
	initial grants_owed = 0;

	task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
	                             input logic [CFG_W-1:0] data);
		if (idx == REG_BOARD_CAPACITY)
			cap_now = (data > BOARD_DEPTH) ? BOARD_DEPTH : int'(data);
		else if (idx == REG_NUM_SOURCES)
			live_sources = (data > MAX_SOURCES) ? MAX_SOURCES : int'(data);
	endtask

	// nearest to the last served value, oldest wins ties
	task automatic serve_nearest(output bit granted, output grant_t g);
		int best;
		int pick;
		int d;
		int i;
		granted = 1'b0;
		g = '0;
		if (board_fill < cap_now || live_sources == 0 || board_fill == 0)
			return;
		best = FAR;
		pick = 0;
		for (i = 0; i < board_fill; i++) begin
			d = int'(board_value[i]) - last_value;
			if (d < 0)
				d = -d;
			if (d < best) begin
				best = d;
				pick = i;
			end
		end
		g.value = board_value[pick];
		g.source = board_source[pick];
		g.dropped = 1'b0;
		last_value = int'(board_value[pick]);
		for (i = pick; i + 1 < board_fill; i++) begin
			board_value[i] = board_value[i + 1];
			board_source[i] = board_source[i + 1];
		end
		board_fill--;
		granted = 1'b1;
	endtask

	task automatic predict_item(input logic m, input logic [VALUE_W-1:0] v,
	                            input logic [SOURCE_W-1:0] s);
		bit     granted;
		grant_t g;
		granted = 1'b0;
		g = '0;
		if (m == MODE_POST) begin
			if (board_fill >= cap_now || board_fill >= BOARD_DEPTH) begin
				g.dropped = 1'b1;
				granted = 1'b1;
			end else begin
				board_value[board_fill] = v;
				board_source[board_fill] = s;
				board_fill++;
				serve_nearest(granted, g);
			end
		end else if (live_sources != 0) begin
			live_sources--;
			if (live_sources < cap_now)
				cap_now--;
			serve_nearest(granted, g);
		end
		if (granted)
			owed_grants = {owed_grants, g};
	endtask

	task automatic check_grant();
		grant_t want;
		bit     bad;
		if (owed_grants.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected grant: value %0d source %0d dropped %0d",
					served_value, served_source, dropped);
			fail_count++;
			return;
		end
		want = owed_grants.pop_front();
		bad = 1'b0;
		if (served_value !== want.value)
			bad = 1'b1;
		if (served_source !== want.source)
			bad = 1'b1;
		if (dropped !== want.dropped)
			bad = 1'b1;
		if (bad) begin
			if (fail_count < 10)
				$display({"grant mismatch: want value %0d source %0d dropped %0d,",
					" got value %0d source %0d dropped %0d"},
					want.value, want.source, want.dropped,
					served_value, served_source, dropped);
			fail_count++;
		end
	endtask

	// grant first, then config, then the new item: a new item never
	// produces its grant in the cycle it is accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BOARD_DEPTH; i++) begin
				board_value[i] = '0;
				board_source[i] = '0;
			end
			board_fill = 0;
			last_value = -1;
			live_sources = RESET_SOURCES;
			cap_now = RESET_CAPACITY;
			owed_grants.delete();
			grants_owed = 0;
		end else begin
			if (out_valid && !out_stall)
				check_grant();
			if (cfg_we)
				load_register(cfg_index, cfg_wdata);
			if (in_valid && !in_stall)
				predict_item(mode, order_value, source_id);
			grants_owed = owed_grants.size();
		end
	end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the nearest value request scheduler: a directed walk through
// far values, ties, source retirement and dropped posts, then random phases
// with bursty requests and a stalling grant receiver; a separate checker
// predicts and compares every grant
// ----------------------------------------------------------------------------
module tb;
	import nvrs_pkg::*;

	localparam int BOARD_DEPTH     = 16;
	localparam int MAX_SOURCES     = 16;
	// the limit sits far above the longest legal quiet stretch
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 75;

	typedef enum int {
		RX_CALM,
		RX_JITTER,
		RX_HOLD
	} rx_pattern_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;
	logic                  in_valid;
	logic                  in_stall;
	logic                  mode;
	logic [VALUE_W-1:0]    order_value;
	logic [SOURCE_W-1:0]   source_id;
	logic                  out_valid;
	logic                  out_stall;
	logic [VALUE_W-1:0]    served_value;
	logic [SOURCE_W-1:0]   served_source;
	logic                  dropped;

	int fail_count;
	int grants_owed;
	int idle_cycles;
	int burst_left;
	int hot_value;
	bit calm_sender;

	nearest_value_request_scheduler_top #(
		.BOARD_DEPTH(BOARD_DEPTH),
		.MAX_SOURCES(MAX_SOURCES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.order_value(order_value),
		.source_id(source_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.served_value(served_value),
		.served_source(served_source),
		.dropped(dropped)
	);

	nvrs_grant_checker #(
		.BOARD_DEPTH(BOARD_DEPTH),
		.MAX_SOURCES(MAX_SOURCES)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.order_value(order_value),
		.source_id(source_id),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.served_value(served_value),
		.served_source(served_source),
		.dropped(dropped),
		.fail_count(fail_count),
		.grants_owed(grants_owed)
	);

	// clock, period 4
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: cycles with no item moving on either channel
	initial idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("nearest_value_request_scheduler_top verification failed");
				$finish;
			end
		end
	end

	// grant receiver: calm stretches, random jitter and long holds
	initial begin
		rx_pattern_t pattern;
		int          run_left;
		pattern = RX_CALM;
		run_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (run_left == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						pattern = RX_CALM;
						run_left = $urandom_range(10, 100);
					end
					1: begin
						pattern = RX_JITTER;
						run_left = $urandom_range(10, 60);
					end
					default: begin
						pattern = RX_HOLD;
						run_left = $urandom_range(1, 24);
					end
				endcase
			end
			run_left--;
			case (pattern)
				RX_CALM:   out_stall <= 1'b0;
				RX_JITTER: out_stall <= $urandom_range(0, 1);
				default:   out_stall <= 1'b1;
			endcase
		end
	end

	// one request item; called and returns just after a falling edge
	task automatic send_item(input logic m, input logic [VALUE_W-1:0] v,
	                         input logic [SOURCE_W-1:0] s);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!calm_sender && $urandom_range(0, 3) != 0)
				gap = $urandom_range(1, 30);
		end
		burst_left--;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		order_value <= v;
		source_id <= s;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic post(input int v, input int s);
		send_item(MODE_POST, VALUE_W'(v), SOURCE_W'(s));
	endtask

	task automatic source_done();
		send_item(MODE_DONE, VALUE_W'($urandom_range(0, 999)),
			SOURCE_W'($urandom_range(0, 15)));
	endtask

	// stop sending, collect every owed grant, let the block go quiet
	task automatic settle_board();
		in_valid <= 1'b0;
		wait (grants_owed == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// both registers on consecutive cycles, block idle
	task automatic set_config(input logic [CFG_W-1:0] cap,
	                          input logic [CFG_W-1:0] srcs);
		cfg_we <= 1'b1;
		cfg_index <= REG_BOARD_CAPACITY;
		cfg_wdata <= cap;
		@(negedge clk);
		cfg_index <= REG_NUM_SOURCES;
		cfg_wdata <= srcs;
		@(negedge clk);
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	// mostly posts with clustered values, a few retiring sources
	task automatic random_item();
		int pick;
		int v;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 8) begin
			source_done();
			return;
		end
		if (pick < 30) begin
			// cluster around a hot spot so near ties are common
			v = hot_value + int'($urandom_range(0, 8)) - 4;
			if (v < 0)
				v = 0;
			if (v > 999)
				v = 999;
		end else if (pick < 40) begin
			v = ($urandom_range(0, 1) != 0) ? 999 : 0;
		end else if (pick < 50) begin
			// evenly spaced values give exact equidistant ties
			v = 250 * int'($urandom_range(0, 3));
		end else begin
			v = $urandom_range(0, 999);
		end
		post(v, $urandom_range(0, 15));
	endtask

	function automatic logic [CFG_W-1:0] pick_capacity();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return CFG_W'($urandom_range(0, 1));
		if (pick < 25)
			return CFG_W'($urandom_range(16, 31));
		return CFG_W'($urandom_range(2, 8));
	endfunction

	function automatic logic [CFG_W-1:0] pick_sources();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			return '0;
		if (pick < 20)
			return CFG_W'($urandom_range(17, 31));
		return CFG_W'($urandom_range(1, 16));
	endfunction

	initial begin
		logic [CFG_W-1:0] cap;
		logic [CFG_W-1:0] srcs;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		mode = MODE_POST;
		order_value = '0;
		source_id = '0;
		burst_left = 0;
		hot_value = 500;
		calm_sender = 1'b0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset setting: capacity 4, four live sources
		// far values: everything 1000 away from -1, oldest goes first
		post(999, 15);
		post(999, 3);
		post(999, 0);
		post(999, 9);
		// nearest to the last served value each time
		post(0, 1);
		post(500, 2);
		post(998, 4);
		post(0, 6);
		post(250, 7);
		// 250 and 750 both 250 from 500, older one wins
		post(750, 8);
		post(0, 10);
		// retiring sources shrink the capacity and serve
		source_done();
		source_done();
		source_done();
		// last source gone, capacity reaches zero, nothing served
		source_done();
		// no live sources: nothing changes
		source_done();
		// zero capacity: post dropped
		post(123, 11);

		// no live sources but room: posts stored, then one dropped
		settle_board();
		set_config(CFG_W'(2), CFG_W'(0));
		post(10, 1);
		post(20, 2);
		post(30, 3);

		// sources above the maximum saturate; a retire serves the full board
		settle_board();
		set_config(CFG_W'(2), CFG_W'(17));
		source_done();
		post(999, 15);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					cap = CFG_W'(31);
					srcs = CFG_W'(16);
				end
				1: begin
					cap = CFG_W'(1);
					srcs = CFG_W'(1);
				end
				2: begin
					cap = CFG_W'(16);
					srcs = CFG_W'(31);
				end
				3: begin
					cap = CFG_W'(0);
					srcs = CFG_W'(5);
				end
				default: begin
					cap = pick_capacity();
					srcs = pick_sources();
				end
			endcase
			settle_board();
			set_config(cap, srcs);
			hot_value = $urandom_range(0, 999);
			// some phases run without sender gaps
			calm_sender = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				random_item();
		end

		settle_board();
		if (fail_count == 0)
			$display("nearest_value_request_scheduler_top verification clean");
		else
			$display("nearest_value_request_scheduler_top verification failed");
		$finish;
	end

endmodule
